### rtl/core/sdsc_pkg.sv
// ----------------------------------------------------------------------------
// sdsc_pkg: shared types and constants for the serial DAC stream capture
// Frame record passed from the front to the back, configuration register
// indexes, default sizes and the status code mapping.
// ----------------------------------------------------------------------------
package sdsc_pkg;

    localparam int SDSC_SAMPLE_BITS  = 16;
    localparam int SDSC_STATUS_LINES = 3;
    localparam int SDSC_QUEUE_DEPTH  = 4;

    localparam int OUT_BITS    = 16;
    localparam int FLAG_BITS   = 6;
    localparam int INTRO_BITS  = 6;
    localparam int COUNT_BITS  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRO_FRAMES = 2'd2;

    localparam logic [INTRO_BITS-1:0] INTRO_RESET = 6'd63;

    // Status line codes
    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_LOW  = 2'd1;
    localparam logic [1:0] STAT_BOTH = 2'd2;
    localparam logic [1:0] STAT_HIGH = 2'd3;

    // Start-up phase of the frame stream
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_ARMED,
        PH_RUN
    } sdsc_phase_t;

    // One frame command: real frame preceded by intro silent frames
    typedef struct packed {
        logic [OUT_BITS-1:0]   left;
        logic [OUT_BITS-1:0]   right;
        logic [FLAG_BITS-1:0]  flags;
        logic [INTRO_BITS-1:0] intro;
    } sdsc_frame_t;

    // Map a {high seen, low seen} pair to its status code
    function automatic logic [1:0] status_code(input logic [1:0] seen);
        logic [1:0] code;
        case (seen)
            2'b01:   code = STAT_LOW;
            2'b10:   code = STAT_HIGH;
            2'b11:   code = STAT_BOTH;
            default: code = STAT_NONE;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/sdsc_front.sv
// ----------------------------------------------------------------------------
// sdsc_front: probe byte decoder
// Holds configuration, detects edges on the probe lines, shifts the serial
// word, latches both channels, collects status levels and issues one frame
// command per qualifying channel-2 latch.
// ----------------------------------------------------------------------------
module sdsc_front
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS  = SDSC_SAMPLE_BITS,
    parameter int STATUS_LINES = SDSC_STATUS_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            probe_byte,
    output logic                  push,
    output sdsc_frame_t           push_frame,
    input  logic                  q_full
);

    localparam int FLAG_W = 2 * STATUS_LINES;

    logic                   monitor_reg;
    logic [COUNT_BITS-1:0]  limit_reg;
    logic [INTRO_BITS-1:0]  intro_reg;

    logic [7:0]             prev_byte_reg;
    logic                   prev_valid_reg;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [OUT_BITS-1:0]    left_reg, left_next;
    logic [OUT_BITS-1:0]    right_val;
    logic [FLAG_W-1:0]      flags_reg, flags_next;
    logic [COUNT_BITS-1:0]  count_reg;
    sdsc_phase_t            phase_reg, phase_next;

    logic [7:0]              diff;
    logic                    stopped;
    logic                    act;
    logic                    sel_rise;
    logic                    clk_fall;
    logic                    l1_fall;
    logic                    l2_fall;
    logic                    nonzero;
    logic                    emit;
    logic [INTRO_BITS-1:0]   intro_cnt;
    logic                    commit;
    logic [SAMPLE_BITS+15:0] ext;

    assign cfg_ready = 1'b1;

    // Classify the byte
    assign stopped  = (limit_reg != '0) && (count_reg > limit_reg);
    assign act      = !stopped && !(prev_valid_reg && (probe_byte == prev_byte_reg));
    assign diff     = probe_byte ^ prev_byte_reg;
    assign sel_rise = diff[4] & probe_byte[4];
    assign clk_fall = diff[0] & ~probe_byte[0];
    assign l1_fall  = diff[3] & ~probe_byte[3];
    assign l2_fall  = act & diff[2] & ~probe_byte[2];

    // Collect status line levels
    always_comb
    begin
        flags_next = flags_reg;
        for (int i = 0; i < STATUS_LINES; i++)
        begin
            if (sel_rise && !(monitor_reg && (i == STATUS_LINES - 1)))
            begin
                if (probe_byte[5 + i])
                    flags_next[2 * i + 1] = 1'b1;
                else
                    flags_next[2 * i] = 1'b1;
            end
        end
        if (monitor_reg && probe_byte[5 + STATUS_LINES - 1])
            flags_next[FLAG_W - 1] = 1'b1;
    end

    // Shift the data bit in from the top and align the word, top bit flipped
    always_comb
    begin
        shift_next = shift_reg;
        if (clk_fall)
            shift_next = {probe_byte[1], shift_reg[SAMPLE_BITS-1:1]};
        ext       = {shift_next ^ {1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 16'b0};
        right_val = ext[SAMPLE_BITS+15 -: OUT_BITS];
        left_next = l1_fall ? right_val : left_reg;
    end

    assign nonzero = (left_next != '0) || (right_val != '0);

    // Phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (l2_fall)
        begin
            unique case (phase_reg)
                PH_FIRST: phase_next = PH_ARMED;
                PH_ARMED: phase_next = nonzero ? PH_RUN : PH_ARMED;
                PH_RUN:   phase_next = PH_RUN;
                default:  phase_next = PH_FIRST;
            endcase
        end
    end

    // Phase outputs
    always_comb
    begin
        emit      = 1'b0;
        intro_cnt = '0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                emit = 1'b0;
            end
            PH_ARMED:
            begin
                emit      = l2_fall && nonzero;
                intro_cnt = intro_reg;
            end
            PH_RUN:
            begin
                emit = l2_fall;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold the byte only when its frame cannot enter the queue
    assign in_stall = q_full && emit;
    assign commit   = in_valid && !in_stall && act;
    assign push     = commit && emit;

    always_comb
    begin
        push_frame.left  = left_next;
        push_frame.right = right_val;
        push_frame.flags = FLAG_BITS'(flags_next);
        push_frame.intro = intro_cnt;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_reg <= 1'b0;
            limit_reg   <= '0;
            intro_reg   <= INTRO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MONITOR_MODE: monitor_reg <= cfg_data[0];
                CFG_FRAME_LIMIT:  limit_reg   <= cfg_data[COUNT_BITS-1:0];
                CFG_INTRO_FRAMES: intro_reg   <= cfg_data[INTRO_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= 8'hFF;
            prev_valid_reg <= 1'b0;
            shift_reg      <= '0;
            left_reg       <= '0;
            flags_reg      <= '0;
            count_reg      <= '0;
            phase_reg      <= PH_FIRST;
        end
        else if (commit)
        begin
            prev_byte_reg  <= probe_byte;
            prev_valid_reg <= 1'b1;
            shift_reg      <= shift_next;
            left_reg       <= left_next;
            phase_reg      <= phase_next;
            if (l2_fall)
                flags_reg <= '0;
            else
                flags_reg <= flags_next;
            if (emit && (count_reg != {COUNT_BITS{1'b1}}))
                count_reg <= count_reg + 1'b1;
        end
    end

    // Stall only when a frame is waiting on a full queue
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled while queue has room");

    // Frame count never steps back
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("frame count decreased");

endmodule

### rtl/core/sdsc_queue.sv
// ----------------------------------------------------------------------------
// sdsc_queue: frame command queue
// Small register queue between the decoder and the frame generator, so
// either side can stall on its own.
// ----------------------------------------------------------------------------
module sdsc_queue
    import sdsc_pkg::*;
#(
    parameter int DEPTH = SDSC_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sdsc_frame_t push_frame,
    output logic        full,
    input  logic        pop,
    output sdsc_frame_t head,
    output logic        not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdsc_frame_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Store the pushed frame
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_frame;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

### rtl/core/sdsc_back.sv
// ----------------------------------------------------------------------------
// sdsc_back: frame generator
// Takes frame commands from the queue, plays out the silent intro frames
// and then the real frame into the output register, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sdsc_back
    import sdsc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sdsc_frame_t                head,
    input  logic                       not_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] left_sample,
    output logic signed [OUT_BITS-1:0] right_sample,
    output logic [1:0]                 status_one,
    output logic [1:0]                 status_two,
    output logic [1:0]                 status_three,
    output logic                       last_of_run
);

    sdsc_frame_t           work_reg, work_next;
    logic                  work_valid_reg, work_valid_next;
    logic [INTRO_BITS-1:0] intro_reg, intro_next;
    logic                  out_valid_reg;

    logic [OUT_BITS-1:0]   left_reg, right_reg;
    logic [1:0]            st1_reg, st2_reg, st3_reg;
    logic                  last_reg;

    logic out_free;
    logic finish;

    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = work_valid_reg && out_free && (intro_reg == '0);
    assign pop      = not_empty && (!work_valid_reg || finish);

    // Step through intro frames, then reload from the queue
    always_comb
    begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        intro_next      = intro_reg;
        if (out_free && work_valid_reg)
        begin
            if (intro_reg != '0)
                intro_next = intro_reg - 1'b1;
            else
                work_valid_next = 1'b0;
        end
        if (pop)
        begin
            work_next       = head;
            work_valid_next = 1'b1;
            intro_next      = head.intro;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            intro_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            intro_reg      <= intro_next;
            if (out_free)
                out_valid_reg <= work_valid_reg;
        end
    end

    // Load the output register with a silent or a real frame
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (out_free && work_valid_reg)
        begin
            if (intro_reg != '0)
            begin
                left_reg  <= '0;
                right_reg <= '0;
                st1_reg   <= STAT_NONE;
                st2_reg   <= STAT_NONE;
                st3_reg   <= STAT_NONE;
                last_reg  <= 1'b0;
            end
            else
            begin
                left_reg  <= work_reg.left;
                right_reg <= work_reg.right;
                st1_reg   <= status_code(work_reg.flags[1:0]);
                st2_reg   <= status_code(work_reg.flags[3:2]);
                st3_reg   <= status_code(work_reg.flags[5:4]);
                last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = $signed(left_reg);
    assign right_sample = $signed(right_reg);
    assign status_one   = st1_reg;
    assign status_two   = st2_reg;
    assign status_three = st3_reg;
    assign last_of_run  = last_reg;

    // Silent intro frames carry nothing
    a_intro_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (left_reg == '0) && (right_reg == '0)
            && (st1_reg == STAT_NONE) && (st2_reg == STAT_NONE) && (st3_reg == STAT_NONE))
        else $error("intro frame carries data");

    // A pending intro count belongs to a live command
    a_intro_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (intro_reg != '0) |-> work_valid_reg)
        else $error("intro count without a frame command");

endmodule

### rtl/core/serial_dac_stream_capture.sv
// Path: frame queue, then back end work register, then output register.
// Throughput: one probe byte per cycle unless in_stall holds it; the back end
// delivers one result per cycle while out_stall is low. A channel-2 latch that
// ends a frame occupies the back end for its intro frames and then the real
// frame; the 4-entry frame queue absorbs bursts, and input stalls only when a
// frame meets a full queue.
// Reset: decoder state, queue pointers and output valid clear; registers take defaults.
// ----------------------------------------------------------------------------
// serial_dac_stream_capture: serial audio DAC bit stream receiver
// Decodes probe bytes into stereo frames with status line codes, held back
// until the first nonzero frame, which is preceded by silent frames.
// ----------------------------------------------------------------------------
module serial_dac_stream_capture
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS  = SDSC_SAMPLE_BITS,
    parameter int STATUS_LINES = SDSC_STATUS_LINES,
    parameter int QUEUE_DEPTH  = SDSC_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 probe_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] left_sample,
    output logic signed [OUT_BITS-1:0] right_sample,
    output logic [1:0]                 status_one,
    output logic [1:0]                 status_two,
    output logic [1:0]                 status_three,
    output logic                       last_of_run
);

    logic        push;
    sdsc_frame_t push_frame;
    logic        q_full;
    logic        pop;
    sdsc_frame_t head;
    logic        not_empty;

    sdsc_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .STATUS_LINES (STATUS_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .probe_byte (probe_byte),
        .push       (push),
        .push_frame (push_frame),
        .q_full     (q_full)
    );

    sdsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty)
    );

    sdsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .status_one   (status_one),
        .status_two   (status_two),
        .status_three (status_three),
        .last_of_run  (last_of_run)
    );

endmodule
